@@ src/encoder_frame_receiver_crc8_assert.svh @@
// Assertion macros for the encoder frame receiver.
// Included by efr_err_track, which checks its own logic; needs no other file.
`ifndef ENCODER_FRAME_RECEIVER_CRC8_ASSERT_SVH
`define ENCODER_FRAME_RECEIVER_CRC8_ASSERT_SVH
`ifndef SYNTH
`define EFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efr: same-cycle check failed");
`define EFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efr: next-cycle check failed");
`else
`define EFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/efr_pkg.sv @@
// Types, codes and the CRC-8 byte step for the encoder frame receiver.
// Has no dependencies; every module file uses it by scoped names.
package efr_pkg;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_POLL = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_NOACK = 2'd2;

    localparam int          CFG_IDX_W   = 2;
    localparam logic [1:0]  CFG_REVERSE = 2'd0;
    localparam logic [1:0]  CFG_OFFSET  = 2'd1;
    localparam int          OFFSET_W    = 25;

    localparam logic [3:0]  FRAME_LEN  = 4'd8;
    localparam logic [3:0]  CRC_LEN    = 4'd7;
    localparam logic [3:0]  COUNT_SAT  = 4'd9;
    localparam logic [3:0]  RUN_MAX    = 4'd15;
    localparam logic [7:0]  CRC_POLY   = 8'h97;
    localparam logic [23:0] HALF_RANGE = 24'h800000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] mot_pos;
        logic [23:0] out_pos_raw;
        logic [23:0] out_pos;
        logic [7:0]  enc_status;
        logic        crc_fault;
        logic        noack_fault;
        logic [15:0] crc_err_total;
        logic [15:0] noack_total;
    } out_t;

    typedef struct packed {
        logic       byte_en;
        logic       poll_en;
        logic       ack_en;
        logic [7:0] data_byte;
    } event_t;

    typedef struct packed {
        logic full;
        logic crc_ok;
    } frame_info_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

@@ src/encoder_frame_receiver_crc8.sv @@
// Encoder frame receiver: input register, frame evaluation, result register.
// Only a poll produces a result, registered from the input register into the result register.
// Throughput: one transaction per cycle, but a poll stalls while a result waits untaken.
// The result register and input register let a new item enter while a result waits.
// Reset (rst_n, asynchronous, active low) clears counts, flags, held values and configuration.
module encoder_frame_receiver_crc8 #(
    parameter int ERROR_LIMIT = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  efr_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output efr_pkg::out_t                    out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [efr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [efr_pkg::OFFSET_W-1:0]     cfg_data
);

    logic                           in_vld_reg;
    efr_pkg::in_t                   in_item_reg;
    logic                           out_vld_reg;
    efr_pkg::out_t                  out_data_reg;
    logic                           reverse_reg;
    logic [efr_pkg::OFFSET_W-1:0]   offset_reg;
    logic                           is_poll;
    logic                           advance;
    efr_pkg::event_t                ev;
    efr_pkg::frame_info_t           frm;
    logic [7:0]                     frame_bytes [0:6];
    logic                           pos_update;
    logic [23:0]                    mot_next;
    logic [23:0]                    raw_next;
    logic [23:0]                    out_next;
    logic [7:0]                     enc_next;
    logic                           crc_fault_next;
    logic                           noack_fault_next;
    logic [15:0]                    crc_total_next;
    logic [15:0]                    noack_total_next;
    efr_pkg::out_t                  result;

    assign is_poll  = (in_item_reg.op == efr_pkg::OP_POLL);
    assign advance  = in_vld_reg && (!is_poll || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    assign ev.byte_en   = advance && (in_item_reg.op == efr_pkg::OP_BYTE);
    assign ev.poll_en   = advance && is_poll;
    assign ev.ack_en    = advance && (in_item_reg.op == efr_pkg::OP_ACK);
    assign ev.data_byte = in_item_reg.data_byte;

    assign pos_update = ev.poll_en && frm.full && frm.crc_ok;

    efr_frame_buf u_frame_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .frame_bytes (frame_bytes),
        .info        (frm)
    );

    efr_pos_track u_pos_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (pos_update),
        .frame_bytes (frame_bytes),
        .reverse     (reverse_reg),
        .offset      (offset_reg),
        .mot_next    (mot_next),
        .raw_next    (raw_next),
        .out_next    (out_next),
        .enc_next    (enc_next)
    );

    efr_err_track #(
        .ERROR_LIMIT (ERROR_LIMIT)
    ) u_err_track (
        .clk              (clk),
        .rst_n            (rst_n),
        .ev               (ev),
        .frm              (frm),
        .crc_fault_next   (crc_fault_next),
        .noack_fault_next (noack_fault_next),
        .crc_total_next   (crc_total_next),
        .noack_total_next (noack_total_next)
    );

    always_comb
    begin
        if (!frm.full)
        begin
            result.status = efr_pkg::ST_NOACK;
        end
        else if (frm.crc_ok)
        begin
            result.status = efr_pkg::ST_GOOD;
        end
        else
        begin
            result.status = efr_pkg::ST_CRC;
        end
        result.mot_pos       = mot_next;
        result.out_pos_raw   = raw_next;
        result.out_pos       = out_next;
        result.enc_status    = enc_next;
        result.crc_fault     = crc_fault_next;
        result.noack_fault   = noack_fault_next;
        result.crc_err_total = crc_total_next;
        result.noack_total   = noack_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            reverse_reg <= 1'b0;
            offset_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (ev.poll_en)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    efr_pkg::CFG_REVERSE: reverse_reg <= cfg_data[0];
                    efr_pkg::CFG_OFFSET:  offset_reg  <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (ev.poll_en)
        begin
            out_data_reg <= result;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/efr_frame_buf.sv @@
// Frame byte store with saturating byte count and running CRC-8 over bytes 0 to 6.
// Depends on efr_pkg.
module efr_frame_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  efr_pkg::event_t      ev,
    output logic [7:0]           frame_bytes [0:6],
    output efr_pkg::frame_info_t info
);

    logic [7:0] store_reg [0:7];
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (ev.poll_en)
        begin
            count_next = 4'd0;
            crc_next   = 8'd0;
        end
        else if (ev.byte_en)
        begin
            if (count_reg < efr_pkg::COUNT_SAT)
            begin
                count_next = count_reg + 4'd1;
            end
            if (count_reg < efr_pkg::CRC_LEN)
            begin
                crc_next = efr_pkg::crc8_update(crc_reg, ev.data_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
            crc_reg   <= 8'd0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev.byte_en && (count_reg < efr_pkg::FRAME_LEN))
        begin
            store_reg[count_reg[2:0]] <= ev.data_byte;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 7; i++) begin
            frame_bytes[i] = store_reg[i];
        end
    end

    assign info.full   = (count_reg == efr_pkg::FRAME_LEN);
    assign info.crc_ok = (crc_reg == store_reg[7]);

endmodule

@@ src/efr_pos_track.sv @@
// Position decode, direction mirror, offset wrap and the held position registers.
// Depends on efr_pkg.
module efr_pos_track (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        update,
    input  logic [7:0]  frame_bytes [0:6],
    input  logic        reverse,
    input  logic [efr_pkg::OFFSET_W-1:0] offset,
    output logic [23:0] mot_next,
    output logic [23:0] raw_next,
    output logic [23:0] out_next,
    output logic [7:0]  enc_next
);

    logic [23:0] mot_reg;
    logic [23:0] raw_reg;
    logic [23:0] out_reg;
    logic [7:0]  enc_reg;
    logic [23:0] mot_dec;
    logic [23:0] raw_dec;
    logic [26:0] diff;
    logic [26:0] wrapped;

    function automatic logic [23:0] decode(input logic [23:0] word, input logic rev);
        logic [23:0] v;
        v = {1'b0, word[23:1]};
        return rev ? (efr_pkg::HALF_RANGE - v) : v;
    endfunction

    always_comb
    begin
        mot_dec = decode({frame_bytes[5], frame_bytes[4], frame_bytes[3]}, reverse);
        raw_dec = decode({frame_bytes[2], frame_bytes[1], frame_bytes[0]}, reverse);
        diff    = {3'b000, raw_dec} - {{2{offset[efr_pkg::OFFSET_W-1]}}, offset};
        if (diff[26])
        begin
            wrapped = diff + {3'b000, efr_pkg::HALF_RANGE};
        end
        else if (diff[25:0] >= {2'b00, efr_pkg::HALF_RANGE})
        begin
            wrapped = diff - {3'b000, efr_pkg::HALF_RANGE};
        end
        else
        begin
            wrapped = diff;
        end
    end

    assign mot_next = update ? mot_dec : mot_reg;
    assign raw_next = update ? raw_dec : raw_reg;
    assign out_next = update ? wrapped[23:0] : out_reg;
    assign enc_next = update ? frame_bytes[6] : enc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mot_reg <= 24'd0;
            raw_reg <= 24'd0;
            out_reg <= 24'd0;
            enc_reg <= 8'd0;
        end
        else
        begin
            mot_reg <= mot_next;
            raw_reg <= raw_next;
            out_reg <= out_next;
            enc_reg <= enc_next;
        end
    end

endmodule

@@ src/efr_err_track.sv @@
// Run counts, sticky fault flags and error totals for CRC and no-answer failures.
// Depends on efr_pkg and the assertion macro header.
`include "encoder_frame_receiver_crc8_assert.svh"
module efr_err_track #(
    parameter int ERROR_LIMIT = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  efr_pkg::event_t      ev,
    input  efr_pkg::frame_info_t frm,
    output logic                 crc_fault_next,
    output logic                 noack_fault_next,
    output logic [15:0]          crc_total_next,
    output logic [15:0]          noack_total_next
);

    localparam logic [3:0] LIMIT = 4'(ERROR_LIMIT);

    logic [3:0]  crc_run_reg;
    logic [3:0]  crc_run_next;
    logic [3:0]  noack_run_reg;
    logic [3:0]  noack_run_next;
    logic        crc_fault_reg;
    logic        noack_fault_reg;
    logic [15:0] crc_total_reg;
    logic [15:0] noack_total_reg;

    function automatic logic [3:0] run_inc(input logic [3:0] r);
        return (r < efr_pkg::RUN_MAX) ? r + 4'd1 : efr_pkg::RUN_MAX;
    endfunction

    always_comb
    begin
        crc_run_next     = crc_run_reg;
        noack_run_next   = noack_run_reg;
        crc_fault_next   = crc_fault_reg;
        noack_fault_next = noack_fault_reg;
        crc_total_next   = crc_total_reg;
        noack_total_next = noack_total_reg;
        if (ev.ack_en)
        begin
            crc_fault_next   = 1'b0;
            noack_fault_next = 1'b0;
        end
        else if (ev.poll_en)
        begin
            if (frm.full)
            begin
                noack_run_next = 4'd0;
                if (frm.crc_ok)
                begin
                    crc_run_next = 4'd0;
                end
                else
                begin
                    crc_run_next   = run_inc(crc_run_reg);
                    crc_total_next = crc_total_reg + 16'd1;
                    if (crc_run_next >= LIMIT)
                    begin
                        crc_fault_next = 1'b1;
                    end
                end
            end
            else
            begin
                noack_run_next   = run_inc(noack_run_reg);
                noack_total_next = noack_total_reg + 16'd1;
                if (noack_run_next >= LIMIT)
                begin
                    noack_fault_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_run_reg     <= 4'd0;
            noack_run_reg   <= 4'd0;
            crc_fault_reg   <= 1'b0;
            noack_fault_reg <= 1'b0;
            crc_total_reg   <= 16'd0;
            noack_total_reg <= 16'd0;
        end
        else
        begin
            crc_run_reg     <= crc_run_next;
            noack_run_reg   <= noack_run_next;
            crc_fault_reg   <= crc_fault_next;
            noack_fault_reg <= noack_fault_next;
            crc_total_reg   <= crc_total_next;
            noack_total_reg <= noack_total_next;
        end
    end

    `EFR_ASSERT_NXT(a_ack_clears, clk, rst_n, ev.ack_en, !crc_fault_reg && !noack_fault_reg)
    `EFR_ASSERT_NXT(a_crc_fault_source, clk, rst_n, !crc_fault_reg && !(ev.poll_en && frm.full && !frm.crc_ok), !crc_fault_reg)
    `EFR_ASSERT_NXT(a_noack_total, clk, rst_n, ev.poll_en && !frm.full, noack_total_reg == 16'($past(noack_total_reg) + 16'd1))
    `EFR_ASSERT_NXT(a_full_clears_run, clk, rst_n, ev.poll_en && frm.full, noack_run_reg == 4'd0)

endmodule
